[rtl/core/br1bd_pkg.sv]
`default_nettype none

package br1bd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int POS_W      = 23;
    localparam int PLANE_W    = 4;
    // Packet counts run from 1 to 128.
    localparam int PKT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_PLANE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST        = REG_COMPRESSED;

    localparam logic [7:0] HDR_NOOP = 8'h80;

    typedef struct packed {
        logic restart;
        logic accept;
        logic move;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic job_final;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/core/br1bd_ctrl.sv]
`default_nettype none

module br1bd_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_we,
    input  logic [br1bd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  br1bd_pkg::t_dp_status           i_status,
    output br1bd_pkg::t_dp_cmd              o_cmd,
    output logic                            o_in_stall
);
    import br1bd_pkg::*;

    typedef enum logic [1:0] {
        S_RESTART,
        S_EMPTY,
        S_JOB
    } t_state;

    t_state r_state, n_state;
    logic   cfg_hit;
    logic   move;
    logic   stall;
    logic   accept;

    always_comb begin
        cfg_hit = i_cfg_we && (i_cfg_index <= REG_LAST);
        // The pending results move into the output register whenever it is free.
        move    = (r_state == S_JOB) && (!i_status.out_valid || !i_out_stall);
        stall   = (r_state == S_RESTART) ||
                  ((r_state == S_JOB) && !(move && i_status.job_final));
        accept  = i_in_valid && !stall;

        n_state = r_state;
        if (cfg_hit) begin
            n_state = S_RESTART;
        end else if (accept) begin
            n_state = S_JOB;
        end else if (r_state == S_RESTART) begin
            n_state = S_EMPTY;
        end else if (move && i_status.job_final) begin
            n_state = S_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESTART;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.restart = (r_state == S_RESTART);
    assign o_cmd.accept  = accept;
    assign o_cmd.move    = move;
    assign o_in_stall    = stall;

endmodule

`default_nettype wire

[rtl/core/br1bd_dpath.sv]
`default_nettype none

module br1bd_dpath #(
    parameter int MAX_ROW_BYTES = 1024,
    parameter int MAX_ROWS      = 1024,
    parameter int MAX_PLANES    = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  br1bd_pkg::t_dp_cmd               i_cmd,
    output br1bd_pkg::t_dp_status            o_status,
    input  logic                             i_cfg_we,
    input  logic [br1bd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [br1bd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_chunk_last,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [7:0]                       o_pixel_first,
    output logic [7:0]                       o_pixel_second,
    output logic [1:0]                       o_pixel_count,
    output logic [br1bd_pkg::POS_W-1:0]      o_write_index,
    output logic                             o_run_last,
    output logic                             o_image_done,
    output logic                             o_corrupt
);
    import br1bd_pkg::*;

    localparam int RLW = $clog2(MAX_ROW_BYTES + 1);
    localparam int RWW = $clog2(MAX_ROWS + 1);
    localparam int CW  = (RLW > PKT_W) ? RLW : PKT_W;
    localparam int RBX = (RLW > CFG_DATA_W) ? RLW : CFG_DATA_W;
    localparam int RWX = (RWW > CFG_DATA_W) ? RWW : CFG_DATA_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_RUN
    } t_phase;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_row_bytes;
    logic [CFG_DATA_W-1:0] r_image_rows;
    logic [PLANE_W-1:0]    r_plane_count;
    logic                  r_mask_plane;
    logic                  r_compressed;

    // Decoder state.
    t_phase             r_phase, n_phase;
    logic [PKT_W-1:0]   r_packet_left, n_packet_left;
    logic [RLW-1:0]     r_row_left, n_row_left;
    logic               r_pad, n_pad;
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic [RWW-1:0]     r_rows_left, n_rows_left;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic               r_finished, n_finished;
    logic               r_error, n_error;

    // Results of the last accepted byte that still wait for the output register.
    logic [PKT_W-1:0]   r_job_cnt;
    logic [7:0]         r_job_value;
    logic [POS_W-1:0]   r_job_pos;
    logic               r_job_done;
    logic               r_job_bad;

    // Output register.
    logic               r_out_valid;
    logic [7:0]         r_pix_first;
    logic [7:0]         r_pix_second;
    logic [1:0]         r_pix_count;
    logic [POS_W-1:0]   r_widx;
    logic               r_run_last;
    logic               r_done;
    logic               r_corrupt;

    logic [RLW-1:0]     eff_rb;
    logic [RWW-1:0]     eff_rows;
    logic [PLANE_W-1:0] eff_planes;
    logic [PLANE_W-1:0] planes_tot;
    logic               rs_finished;

    logic               ignored;
    logic [PKT_W-1:0]   hdr_cnt;
    logic [CW:0]        room;
    logic               overrun;
    logic [PKT_W-1:0]   consume;
    logic [CW-1:0]      take;
    logic [CW-1:0]      rl;
    logic [CW-1:0]      d;
    logic [CW-1:0]      rl_new;
    logic               data_row;
    logic [PKT_W-1:0]   emits;
    logic               fin_now;
    logic               pad1;
    logic [PLANE_W-1:0] plane1;
    logic [PKT_W-1:0]   job_step;

    always_comb begin
        eff_rb     = (RBX'(r_row_bytes) > RBX'(MAX_ROW_BYTES)) ?
                     RLW'(MAX_ROW_BYTES) : RLW'(r_row_bytes);
        eff_rows   = (RWX'(r_image_rows) > RWX'(MAX_ROWS)) ?
                     RWW'(MAX_ROWS) : RWW'(r_image_rows);
        eff_planes = (r_plane_count > PLANE_W'(MAX_PLANES)) ?
                     PLANE_W'(MAX_PLANES) : r_plane_count;
        planes_tot = eff_planes + PLANE_W'(r_mask_plane);
        rs_finished = (eff_rb == '0) || (eff_rows == '0) || (eff_planes == '0);
    end

    // One accepted byte: take it raw or decode the header or packet phase, then
    // consume its stored positions. A run never crosses a plane row, since the
    // header check rejects it, so the positions it takes are settled in one step.
    always_comb begin
        n_phase       = r_phase;
        n_packet_left = r_packet_left;
        n_row_left    = r_row_left;
        n_pad         = r_pad;
        n_plane       = r_plane;
        n_rows_left   = r_rows_left;
        n_out_pos     = r_out_pos;
        n_finished    = r_finished;
        n_error       = r_error;

        ignored = r_finished || r_error;
        hdr_cnt = i_data_byte[7] ? (8'd1 - i_data_byte) : (i_data_byte + 8'd1);
        room    = (CW+1)'(r_row_left) + (CW+1)'(r_pad);
        overrun = ((CW+1)'(hdr_cnt) > room);
        consume = '0;

        if (!ignored) begin
            if (!r_compressed) begin
                consume = PKT_W'(1);
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (i_data_byte != HDR_NOOP) begin
                            if (overrun) begin
                                n_error = 1'b1;
                            end else begin
                                n_phase       = i_data_byte[7] ? PH_RUN : PH_LITERAL;
                                n_packet_left = hdr_cnt;
                            end
                        end
                    end
                    PH_LITERAL: begin
                        consume = PKT_W'(1);
                        if (r_packet_left != '0) begin
                            n_packet_left = r_packet_left - PKT_W'(1);
                        end
                        if (r_packet_left <= PKT_W'(1)) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_RUN: begin
                        consume       = r_packet_left;
                        n_packet_left = '0;
                        n_phase       = PH_HEADER;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end

        take     = CW'(consume);
        rl       = CW'(r_row_left);
        d        = (take < rl) ? take : rl;
        rl_new   = rl - d;
        data_row = (r_plane < eff_planes);
        emits    = data_row ? PKT_W'(d) : '0;
        fin_now  = data_row && (d == rl) && (d != '0) &&
                   (r_plane == eff_planes - PLANE_W'(1)) && (r_rows_left == RWW'(1));
        pad1     = (take > rl) ? 1'b0 : r_pad;
        plane1   = r_plane + PLANE_W'(1);

        if (consume != '0) begin
            n_out_pos = r_out_pos + POS_W'(emits);
            if (fin_now) begin
                n_finished = 1'b1;
                n_row_left = '0;
            end else if ((rl_new == '0) && !pad1) begin
                // Plane row done: step to the next plane, or the next image row
                // after the last plane (the mask plane, if enabled).
                n_row_left = eff_rb;
                n_pad      = eff_rb[0];
                if (plane1 >= planes_tot) begin
                    n_plane = '0;
                    if (r_rows_left != '0) begin
                        n_rows_left = r_rows_left - RWW'(1);
                    end
                end else begin
                    n_plane = plane1;
                end
            end else begin
                n_row_left = RLW'(rl_new);
                n_pad      = pad1;
            end
        end

        job_step = (r_job_cnt > PKT_W'(2)) ? PKT_W'(2) : r_job_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= CFG_DATA_W'(1);
            r_image_rows  <= CFG_DATA_W'(1);
            r_plane_count <= PLANE_W'(1);
            r_mask_plane  <= 1'b0;
            r_compressed  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_BYTES:   r_row_bytes   <= i_cfg_data;
                REG_IMAGE_ROWS:  r_image_rows  <= i_cfg_data;
                REG_PLANE_COUNT: r_plane_count <= i_cfg_data[PLANE_W-1:0];
                REG_MASK_PLANE:  r_mask_plane  <= i_cfg_data[0];
                REG_COMPRESSED:  r_compressed  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_finished <= 1'b0;
            r_error    <= 1'b0;
        end else if (i_cmd.restart || (i_cmd.accept && i_chunk_last)) begin
            r_phase       <= PH_HEADER;
            r_packet_left <= '0;
            r_row_left    <= eff_rb;
            r_pad         <= eff_rb[0];
            r_plane       <= '0;
            r_rows_left   <= eff_rows;
            r_out_pos     <= '0;
            r_finished    <= rs_finished;
            r_error       <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase       <= n_phase;
            r_packet_left <= n_packet_left;
            r_row_left    <= n_row_left;
            r_pad         <= n_pad;
            r_plane       <= n_plane;
            r_rows_left   <= n_rows_left;
            r_out_pos     <= n_out_pos;
            r_finished    <= n_finished;
            r_error       <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // A move takes the oldest pair of the job; a new byte reloads the job at
    // the same edge when the old one has just left.
    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            r_pix_count  <= job_step[1:0];
            r_pix_first  <= (r_job_cnt != '0) ? r_job_value : 8'd0;
            r_pix_second <= (r_job_cnt > PKT_W'(1)) ? r_job_value : 8'd0;
            r_widx       <= r_job_pos;
            r_run_last   <= (r_job_cnt <= PKT_W'(2));
            r_done       <= r_job_done;
            r_corrupt    <= r_job_bad;
        end
        if (i_cmd.accept) begin
            r_job_cnt   <= emits;
            r_job_value <= i_data_byte;
            r_job_pos   <= r_out_pos;
            r_job_done  <= n_finished;
            r_job_bad   <= n_error || (i_chunk_last && !n_finished);
        end else if (i_cmd.move) begin
            r_job_cnt <= r_job_cnt - job_step;
            r_job_pos <= r_job_pos + POS_W'(2);
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_status.job_final = (r_job_cnt <= PKT_W'(2));

    assign o_out_valid    = r_out_valid;
    assign o_pixel_first  = r_pix_first;
    assign o_pixel_second = r_pix_second;
    assign o_pixel_count  = r_pix_count;
    assign o_write_index  = r_widx;
    assign o_run_last     = r_run_last;
    assign o_image_done   = r_done;
    assign o_corrupt      = r_corrupt;

endmodule

`default_nettype wire

[rtl/core/byterun1_bitmap_body_decoder_core.sv]
`default_nettype none

// ByteRun1 bitmap body decoder. Body bytes come in one beat each; every beat
// yields one or more result beats with up to two pixel bytes and their image
// buffer index, the last one flagged by run_last. A header, literal or raw
// byte yields one result beat; a repeat run holds the input until its last
// pair moves, as the output register takes one pair per cycle unless
// the output stalls. After reset and after each write to a known register
// the decoder reloads its row and plane counters with the input stalled.
// Write configuration only while no results are outstanding; any such write,
// and every chunk_last beat, restarts the decoder at the top of the bitmap.
module byterun1_bitmap_body_decoder_core #(
    parameter int MAX_ROW_BYTES = 1024,
    parameter int MAX_ROWS      = 1024,
    parameter int MAX_PLANES    = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_chunk_last,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_pixel_first,
    output logic [7:0]                       o_pixel_second,
    output logic [1:0]                       o_pixel_count,
    output logic [br1bd_pkg::POS_W-1:0]      o_write_index,
    output logic                             o_run_last,
    output logic                             o_image_done,
    output logic                             o_corrupt,
    input  logic                             i_cfg_we,
    input  logic [br1bd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [br1bd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import br1bd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    br1bd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    br1bd_dpath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_PLANES    (MAX_PLANES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_data_byte    (i_data_byte),
        .i_chunk_last   (i_chunk_last),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_count  (o_pixel_count),
        .o_write_index  (o_write_index),
        .o_run_last     (o_run_last),
        .o_image_done   (o_image_done),
        .o_corrupt      (o_corrupt)
    );

`ifndef SYNTHESIS
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pixel_count == 2'd0)) |-> o_run_last)
        else $error("status-only beat is not the last beat of its byte");

    a_pairs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_run_last) |-> (o_pixel_count == 2'd2))
        else $error("beat before the last one of a run is not a full pair");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_run_last) |=> o_out_valid)
        else $error("run output paused with pairs still pending");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_image_done) |-> !o_corrupt)
        else $error("finished bitmap reported as corrupt");
`endif

endmodule

`default_nettype wire

[dv/byterun1_bitmap_body_decoder_core_tb.sv]
`timescale 1ns / 100ps

module byterun1_bitmap_body_decoder_core_tb;

    import br1bd_pkg::*;

    localparam int ROW_BYTES_CAP  = 1024;
    localparam int ROWS_CAP       = 1024;
    localparam int PLANES_CAP     = 8;
    localparam int PHASE_ITEMS    = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_NS     = 10_000_000;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_LITERAL,
        DEC_RUN
    } t_dec_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_body_byte;

    typedef struct packed {
        logic [7:0]       px_first;
        logic [7:0]       px_second;
        logic [1:0]       px_count;
        logic [POS_W-1:0] wr_index;
        logic             run_last;
        logic             img_done;
        logic             corrupt;
    } t_pixel_beat;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte    = '0;
    logic                  i_chunk_last   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [7:0]            o_pixel_first;
    logic [7:0]            o_pixel_second;
    logic [1:0]            o_pixel_count;
    logic [POS_W-1:0]      o_write_index;
    logic                  o_run_last;
    logic                  o_image_done;
    logic                  o_corrupt;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    byterun1_bitmap_body_decoder_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_chunk_last   (i_chunk_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_count  (o_pixel_count),
        .o_write_index  (o_write_index),
        .o_run_last     (o_run_last),
        .o_image_done   (o_image_done),
        .o_corrupt      (o_corrupt),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow copy of the configuration and the decoder state.
    logic [10:0]      cfg_row_bytes  = 11'd1;
    logic [10:0]      cfg_image_rows = 11'd1;
    logic [3:0]       cfg_planes     = 4'd1;
    logic             cfg_mask       = 1'b0;
    logic             cfg_compressed = 1'b1;

    t_dec_phase       dec_phase;
    logic [7:0]       pkt_left;
    logic [11:0]      row_left;
    logic             pad_pending;
    logic [3:0]       plane_idx;
    logic [10:0]      rows_left;
    logic [POS_W-1:0] out_pos;
    logic             finished;
    logic             err_seen;

    t_body_byte  body_q[$];
    t_pixel_beat pixel_q[$];
    int          items_pending = 0;
    int          phase_items   = 0;
    int          error_count   = 0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    logic        rx_hold_tgl   = 1'b0;
    logic        rx_hold_seen  = 1'b0;
    int          rx_hold_left  = 0;

    function automatic int sat_rb();
        return (cfg_row_bytes > ROW_BYTES_CAP) ? ROW_BYTES_CAP : int'(cfg_row_bytes);
    endfunction

    function automatic int sat_rows();
        return (cfg_image_rows > ROWS_CAP) ? ROWS_CAP : int'(cfg_image_rows);
    endfunction

    function automatic int sat_planes();
        return (cfg_planes > PLANES_CAP) ? PLANES_CAP : int'(cfg_planes);
    endfunction

    function automatic void restart_decoder();
        dec_phase   = DEC_HEADER;
        pkt_left    = '0;
        row_left    = 12'(sat_rb());
        pad_pending = 1'(sat_rb() & 1);
        plane_idx   = '0;
        rows_left   = 11'(sat_rows());
        out_pos     = '0;
        err_seen    = 1'b0;
        finished    = (sat_rb() == 0 || sat_rows() == 0 || sat_planes() == 0);
    endfunction

    // Steps over one stored byte position; returns 1 when it lands in the image.
    function automatic bit take_slot(output logic [POS_W-1:0] pos);
        int planes;
        bit wrote;
        planes = sat_planes();
        wrote  = 1'b0;
        pos    = '0;
        if (finished || err_seen) begin
            return 1'b0;
        end
        if (row_left > 0) begin
            row_left--;
            if (plane_idx < planes) begin
                pos     = out_pos;
                out_pos = out_pos + 1'b1;
                wrote   = 1'b1;
                if (row_left == 0 && plane_idx == planes - 1 && rows_left == 1) begin
                    finished = 1'b1;
                    return 1'b1;
                end
            end
        end else if (pad_pending) begin
            pad_pending = 1'b0;
        end
        // End of a plane row: move on to the next plane, mask or image row.
        if (row_left == 0 && !pad_pending) begin
            plane_idx++;
            if (plane_idx >= planes + cfg_mask) begin
                plane_idx = '0;
                if (rows_left > 0) begin
                    rows_left--;
                end
            end
            row_left    = 12'(sat_rb());
            pad_pending = 1'(sat_rb() & 1);
        end
        return wrote;
    endfunction

    function automatic void predict_pixels(logic [7:0] b, logic last);
        logic [7:0]       vals [0:127];
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] pos;
        int               k;
        int               cnt;
        int               nres;
        bit               done_now;
        bit               bad_now;
        t_pixel_beat      beat;
        k         = 0;
        first_pos = '0;
        if (finished || err_seen) begin
            // Nothing to do until the chunk ends.
        end else if (!cfg_compressed) begin
            if (take_slot(pos)) begin
                first_pos = pos;
                vals[k]   = b;
                k++;
            end
        end else if (dec_phase == DEC_HEADER) begin
            if (b != HDR_NOOP) begin
                cnt = b[7] ? 257 - int'(b) : int'(b) + 1;
                if (cnt > int'(row_left) + int'(pad_pending)) begin
                    err_seen = 1'b1;
                end else begin
                    dec_phase = b[7] ? DEC_RUN : DEC_LITERAL;
                    pkt_left  = 8'(cnt);
                end
            end
        end else if (dec_phase == DEC_LITERAL) begin
            if (take_slot(pos)) begin
                first_pos = pos;
                vals[k]   = b;
                k++;
            end
            if (pkt_left > 0) begin
                pkt_left--;
            end
            if (pkt_left == 0) begin
                dec_phase = DEC_HEADER;
            end
        end else begin
            for (int i = 0; i < pkt_left && i < 128; i++) begin
                if (take_slot(pos)) begin
                    if (k == 0) begin
                        first_pos = pos;
                    end
                    vals[k] = b;
                    k++;
                end
            end
            pkt_left  = '0;
            dec_phase = DEC_HEADER;
        end

        done_now = finished;
        bad_now  = err_seen || (last && !finished);
        nres     = (k != 0) ? (k + 1) / 2 : 1;
        for (int i = 0; i < nres; i++) begin
            beat = '0;
            if (k == 0) begin
                beat.wr_index = out_pos;
            end else begin
                beat.px_first = vals[2 * i];
                if (2 * i + 1 < k) begin
                    beat.px_second = vals[2 * i + 1];
                    beat.px_count  = 2'd2;
                end else begin
                    beat.px_count = 2'd1;
                end
                beat.wr_index = POS_W'(first_pos + 2 * i);
            end
            beat.run_last = (i == nres - 1);
            beat.img_done = done_now;
            beat.corrupt  = bad_now;
            pixel_q.push_back(beat);
        end
        if (last) begin
            restart_decoder();
        end
    endfunction

    function automatic void queue_byte(logic [7:0] d, logic last = 1'b0);
        t_body_byte item;
        item.data = d;
        item.last = last;
        body_q.push_back(item);
        items_pending++;
        phase_items++;
    endfunction

    function automatic void mark_chunk_end();
        t_body_byte item;
        item      = body_q.pop_back();
        item.last = 1'b1;
        body_q.push_back(item);
    endfunction

    // Builds a chunk that follows the row layout of the current settings. It stops
    // early once at least max_items bytes are queued, which leaves the image short.
    function automatic void gen_body_chunk(int max_items);
        int rb;
        int rows_total;
        int room;
        int lim;
        int cnt;
        int used;
        bit whole;
        rb         = sat_rb();
        rows_total = sat_rows() * (sat_planes() + cfg_mask);
        used       = 0;
        whole      = 1'b1;
        for (int r = 0; r < rows_total && whole; r++) begin
            room = rb + (rb & 1);
            while (room > 0 && whole) begin
                if (used >= max_items) begin
                    whole = 1'b0;
                end else if (!cfg_compressed) begin
                    queue_byte(8'($urandom_range(255)));
                    used++;
                    room--;
                end else begin
                    if ($urandom_range(15) == 0) begin
                        queue_byte(HDR_NOOP);
                        used++;
                    end
                    lim = (room < 128) ? room : 128;
                    case ($urandom_range(3))
                        0: cnt = lim;
                        1: cnt = 1 + $urandom_range(((lim < 4) ? lim : 4) - 1);
                        default: cnt = 1 + $urandom_range(lim - 1);
                    endcase
                    if (cnt > 12 || (cnt >= 2 && $urandom_range(1) == 1)) begin
                        queue_byte(8'(257 - cnt));
                        queue_byte(8'($urandom_range(255)));
                        used += 2;
                    end else begin
                        queue_byte(8'(cnt - 1));
                        repeat (cnt) queue_byte(8'($urandom_range(255)));
                        used += cnt + 1;
                    end
                    room -= cnt;
                end
            end
        end
        // Bytes past the end of a complete image are consumed and ignored.
        if ((whole && $urandom_range(2) == 0) || used == 0) begin
            repeat (1 + $urandom_range(1)) queue_byte(8'($urandom_range(255)));
        end
        mark_chunk_end();
    endfunction

    function automatic void gen_noise_chunk(int len);
        repeat (len) queue_byte(8'($urandom_range(255)));
        mark_chunk_end();
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        case (idx)
            REG_ROW_BYTES:   cfg_row_bytes  = 11'(val);
            REG_IMAGE_ROWS:  cfg_image_rows = 11'(val);
            REG_PLANE_COUNT: cfg_planes     = 4'(val);
            REG_MASK_PLANE:  cfg_mask       = 1'(val);
            REG_COMPRESSED:  cfg_compressed = 1'(val);
            default: ;
        endcase
        restart_decoder();
        @(posedge i_clk);
    endtask

    task automatic apply_config(int rb, int rows, int planes, int mask, int comp);
        write_reg(REG_ROW_BYTES, rb);
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_PLANE_COUNT, planes);
        write_reg(REG_MASK_PLANE, mask);
        write_reg(REG_COMPRESSED, comp);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (items_pending != 0 || pixel_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input side: offers queued bytes and predicts the results of each accepted beat.
    always @(posedge i_clk) begin
        t_body_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_pixels(i_data_byte, i_chunk_last);
                items_pending--;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (body_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = body_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= nxt.data;
                    i_chunk_last <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, and a toggle of rx_hold_tgl starts one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall  <= 1'b0;
            rx_hold_seen <= rx_hold_tgl;
            rx_hold_left <= 0;
        end else if (rx_hold_tgl != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_tgl;
            rx_hold_left <= RX_HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected result beat, write_index %0d", o_write_index);
                error_count++;
            end else begin
                want = pixel_q.pop_front();
                check_field("pixel_first", want.px_first, o_pixel_first);
                check_field("pixel_second", want.px_second, o_pixel_second);
                check_field("pixel_count", want.px_count, o_pixel_count);
                check_field("write_index", want.wr_index, o_write_index);
                check_field("run_last", want.run_last, o_run_last);
                check_field("image_done", want.img_done, o_image_done);
                check_field("corrupt", want.corrupt, o_corrupt);
            end
        end
    end

    initial begin
        bit paused;
        restart_decoder();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Three-byte rows with a pad byte, two image rows, each with a mask row.
        apply_config(3, 2, 1, 1, 1);
        queue_byte(HDR_NOOP);
        queue_byte(8'h02);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h55);
        // A one-byte literal that only covers the pad byte.
        queue_byte(8'h00);
        queue_byte(8'hAA);
        // A run across the whole mask row, pad included.
        queue_byte(8'hFD);
        queue_byte(8'h77);
        // This run completes the bitmap partway through.
        queue_byte(8'hFD);
        queue_byte(8'hEE);
        queue_byte(8'h81, 1'b1);
        // Largest literal overruns the row; the rest of the chunk is dropped.
        queue_byte(8'h7F);
        queue_byte(8'h12);
        queue_byte(8'h34, 1'b1);
        // Chunks that end before the bitmap is complete.
        queue_byte(8'h00);
        queue_byte(8'h34, 1'b1);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(HDR_NOOP, 1'b1);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: apply_config(5, 3, 2, 0, 1);
                1: apply_config(4, 2, 1, 1, 0);
                2: apply_config(1, 1, 1, 0, 1);
                3: apply_config(200, 1, 1, 0, 1);
                4: apply_config(7, 2, 8, 1, 1);
                5: apply_config(1024, 1024, 8, 1, 1);
                6: apply_config(2047, 2047, 15, 0, 1);
                7: apply_config(0, 5, 3, 1, 1);
                default: apply_config(3, 2, 3, 1, 0);
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            phase_items = 0;
            paused      = 1'b0;
            if (finished) begin
                // Empty bitmap: every byte is ignored.
                gen_noise_chunk(10);
            end else begin
                while (phase_items < PHASE_ITEMS) begin
                    if (p == 1 && !paused && phase_items >= PHASE_ITEMS / 2) begin
                        wait_drained();
                        paused = 1'b1;
                    end
                    if ($urandom_range(9) < 7) begin
                        gen_body_chunk(20 + $urandom_range(40));
                    end else begin
                        gen_noise_chunk(1 + $urandom_range(7));
                    end
                end
            end
            if (p == 0) begin
                @(posedge i_clk);
                rx_hold_tgl <= ~rx_hold_tgl;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[byterun1_bitmap_body_decoder_core.f]
rtl/core/br1bd_pkg.sv
rtl/core/br1bd_ctrl.sv
rtl/core/br1bd_dpath.sv
rtl/core/byterun1_bitmap_body_decoder_core.sv
dv/byterun1_bitmap_body_decoder_core_tb.sv
